@@ rtl/msph_pkg.sv @@
`default_nettype none
package msph_pkg;

    typedef enum logic [1:0] {
        OP_ATOM  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_EOF   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_BOX_Z = 3'd0,
        REG_BINS0 = 3'd1,
        REG_BINS1 = 3'd2,
        REG_BINS2 = 3'd3,
        REG_BINS3 = 3'd4
    } t_reg_idx;

    localparam int NUM_REG  = 4;
    localparam int CFG_W    = 24;
    localparam int BOX_W    = 24;
    localparam int BINS_W   = 10;
    localparam int FIELD_W  = 25;
    localparam int CEN_W    = 26;
    localparam int PROD_W   = BOX_W + BINS_W;

    localparam logic [BOX_W-1:0]  BOX_Z_RST = 24'd10000;
    localparam logic [BINS_W-1:0] BINS_RST [NUM_REG] = '{10'd50, 10'd100, 10'd200, 10'd300};

    // one histogram entry
    typedef struct packed {
        logic [31:0]        cnt;
        logic signed [63:0] vz;
        logic [63:0]        sq;
    } t_entry;

endpackage
`default_nettype wire

@@ rtl/msph_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module msph_div #(
    parameter int NW = 34,
    parameter int DW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo
);
    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [NW-1:0]    r_quo;

    logic [DW:0]   w_sh;
    logic [DW:0]   w_sub;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    always_comb begin
        w_sh  = {r_rem, r_quo[NW-1]};
        w_ge  = w_sh >= {1'b0, r_den};
        w_sub = w_sh - {1'b0, r_den};
        n_rem = w_ge ? w_sub[DW-1:0] : w_sh[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

@@ rtl/msph_mem.sv @@
`default_nettype none
// single-port-write, registered-read table
module msph_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 160
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [DW-1:0]      o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/molecule_slab_profile_histogram.sv @@
// Slab density profile histogram. Atoms arrive one beat per start pulse and are
// summed per molecule; the atom flagged last (or an end-of-frame beat with atoms
// pending) finishes the molecule: its centroid is taken by truncating division,
// its squared speed formed, and for each resolution its z is binned as
// floor(z*bins/box_z) and the (resolution, type, bin) entry gets a saturating
// read-modify-write of count, z velocity sum and squared speed sum. Every beat
// gives exactly one result, strobed by o_done for one cycle; the receiver cannot
// stall it, so the block never holds a result back. A plain atom or an
// out-of-range read gives its result the next cycle; a table read goes through
// S_RD and S_RRET. A finishing beat passes setup, the centroid divider, the
// squarer, then per resolution the bin divider and memory read/write unless
// dropped, and closes out; the iterative dividers dominate its time.
// After reset, and on a clear beat, a clearing pass writes zeros to every table
// entry (NUM_RES*NUM_TYPES*MAX_BINS, 16384 by default), one per cycle, with busy
// high. Configuration writes are taken at any time.
`default_nettype none
module molecule_slab_profile_histogram
    import msph_pkg::*;
#(
    parameter int MAX_BINS          = 512,
    parameter int NUM_TYPES         = 8,
    parameter int NUM_RES           = 4,
    parameter int MAX_ATOMS_PER_MOL = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [2:0]         i_mol_type,
    input  wire logic               i_end_of_molecule,
    input  wire logic signed [24:0] i_pos_z,
    input  wire logic signed [24:0] i_vel_x,
    input  wire logic signed [24:0] i_vel_y,
    input  wire logic signed [24:0] i_vel_z,
    input  wire logic [1:0]         i_resolution_select,
    input  wire logic [8:0]         i_bin_index,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    output logic                    o_done,
    output logic [31:0]             o_entry_count,
    output logic signed [63:0]      o_vz_sum,
    output logic [63:0]             o_speed_sq_sum,
    output logic [31:0]             o_frames_seen,
    output logic                    o_dropped
);
    localparam int DEPTH  = NUM_RES * NUM_TYPES * MAX_BINS;
    localparam int AW     = $clog2(DEPTH);
    localparam int TW     = $clog2(MAX_ATOMS_PER_MOL + 1);
    localparam int ACC_W  = FIELD_W + 1 + $clog2(MAX_ATOMS_PER_MOL);
    localparam int NR_ACT = (NUM_RES < NUM_REG) ? NUM_RES : NUM_REG;
    localparam int EW     = $bits(t_entry);

    typedef enum logic [10:0] {
        S_CLR    = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_FIN    = 11'b000_0000_0100,
        S_DIV    = 11'b000_0000_1000,
        S_SQ     = 11'b000_0001_0000,
        S_BIN    = 11'b000_0010_0000,
        S_BWAIT  = 11'b000_0100_0000,
        S_RMW_RD = 11'b000_1000_0000,
        S_RMW_WR = 11'b001_0000_0000,
        S_RD     = 11'b010_0000_0000,
        S_RRET   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [BOX_W-1:0]  r_box;
    logic [BINS_W-1:0] r_bins [NUM_REG];

    // pending molecule
    logic signed [ACC_W-1:0] r_z_acc, r_vx_acc, r_vy_acc, r_vz_acc;
    logic signed [ACC_W-1:0] n_z_acc, n_vx_acc, n_vy_acc, n_vz_acc;
    logic [TW-1:0]           r_tally, n_tally;
    logic [2:0]              r_type, n_type;

    // finish path
    logic                    r_eof, n_eof;
    logic                    r_drop, n_drop;
    logic signed [CEN_W-1:0] r_cz, r_cvx, r_cvy, r_cvz;
    logic signed [CEN_W-1:0] n_cz, n_cvx, n_cvy, n_cvz;
    logic [1:0]              r_k, n_k;
    logic [2*CEN_W-1:0]      r_prod, n_prod;
    logic [63:0]             r_sq, n_sq;
    logic [2:0]              r_res, n_res;
    logic [AW-1:0]           r_addr, n_addr;
    logic [AW-1:0]           r_clr_cnt, n_clr_cnt;
    logic                    r_clr_emit, n_clr_emit;
    logic [31:0]             r_frames, n_frames;

    // result registers
    logic               r_done, n_done;
    logic [31:0]        r_cnt_o, n_cnt_o;
    logic signed [63:0] r_vz_o, n_vz_o;
    logic [63:0]        r_sq_o, n_sq_o;
    logic               r_drop_o, n_drop_o;

    // centroid dividers: four lanes on the magnitudes
    logic [ACC_W-1:0] w_mag [4];
    logic [ACC_W-1:0] w_quo [4];
    logic [3:0]       w_cdone;
    logic             w_cdiv_start;
    logic             w_cdiv_done;

    // bin divider
    logic              w_bdiv_start;
    logic              w_bdiv_done;
    logic [PROD_W-1:0] w_bnum;
    logic [PROD_W-1:0] w_bquo;
    logic [BINS_W-1:0] w_bins_cur;

    // table
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [EW-1:0] w_rdata;
    t_entry        w_old, w_new;
    logic signed [64:0] w_vz_sum;
    logic [64:0]        w_sq_sum;

    logic                    w_accept;
    logic signed [CEN_W-1:0] w_sq_sel;
    logic                    w_rd_ok;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    assign w_mag[0] = r_z_acc[ACC_W-1]  ? ACC_W'(-r_z_acc)  : ACC_W'(r_z_acc);
    assign w_mag[1] = r_vx_acc[ACC_W-1] ? ACC_W'(-r_vx_acc) : ACC_W'(r_vx_acc);
    assign w_mag[2] = r_vy_acc[ACC_W-1] ? ACC_W'(-r_vy_acc) : ACC_W'(r_vy_acc);
    assign w_mag[3] = r_vz_acc[ACC_W-1] ? ACC_W'(-r_vz_acc) : ACC_W'(r_vz_acc);

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_cdiv
            msph_div #(.NW(ACC_W), .DW(TW)) u_cdiv (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (w_cdiv_start),
                .i_num   (w_mag[g]),
                .i_den   (r_tally),
                .o_done  (w_cdone[g]),
                .o_quo   (w_quo[g])
            );
        end
    endgenerate
    assign w_cdiv_done = &w_cdone;

    assign w_bins_cur = r_bins[r_res[1:0]];
    // cz is known non-negative here and below 2^24
    assign w_bnum     = PROD_W'(r_cz[BOX_W-1:0]) * PROD_W'(w_bins_cur);

    msph_div #(.NW(PROD_W), .DW(BOX_W)) u_bdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bdiv_start),
        .i_num   (w_bnum),
        .i_den   (r_box),
        .o_done  (w_bdiv_done),
        .o_quo   (w_bquo)
    );

    msph_mem #(.DEPTH(DEPTH), .AW(AW), .DW(EW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // saturating update of the entry under modification
    always_comb begin
        w_old    = t_entry'(w_rdata);
        w_new    = w_old;
        w_vz_sum = $signed({w_old.vz[63], w_old.vz}) + 65'(r_cvz);
        w_sq_sum = {1'b0, w_old.sq} + {1'b0, r_sq};
        if (w_old.cnt != 32'hFFFF_FFFF) begin
            w_new.cnt = w_old.cnt + 32'd1;
        end
        if (w_vz_sum[64] != w_vz_sum[63]) begin
            w_new.vz = w_vz_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            w_new.vz = w_vz_sum[63:0];
        end
        w_new.sq = w_sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_sq_sum[63:0];
    end

    assign w_we    = (r_state == S_CLR) || (r_state == S_RMW_WR);
    assign w_waddr = (r_state == S_CLR) ? r_clr_cnt : r_addr;
    assign w_wdata = (r_state == S_CLR) ? '0 : EW'(w_new);

    assign w_rd_ok = (32'(i_resolution_select) < NUM_RES) && (32'(i_mol_type) < NUM_TYPES)
                  && (32'(i_bin_index) < MAX_BINS);

    always_comb begin
        case (r_k)
            2'd0:    w_sq_sel = r_cvx;
            2'd1:    w_sq_sel = r_cvy;
            default: w_sq_sel = r_cvz;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_z_acc    = r_z_acc;
        n_vx_acc   = r_vx_acc;
        n_vy_acc   = r_vy_acc;
        n_vz_acc   = r_vz_acc;
        n_tally    = r_tally;
        n_type     = r_type;
        n_eof      = r_eof;
        n_drop     = r_drop;
        n_cz       = r_cz;
        n_cvx      = r_cvx;
        n_cvy      = r_cvy;
        n_cvz      = r_cvz;
        n_k        = r_k;
        n_prod     = r_prod;
        n_sq       = r_sq;
        n_res      = r_res;
        n_addr     = r_addr;
        n_clr_cnt  = r_clr_cnt;
        n_clr_emit = r_clr_emit;
        n_frames   = r_frames;
        n_done     = 1'b0;
        n_cnt_o    = r_cnt_o;
        n_vz_o     = r_vz_o;
        n_sq_o     = r_sq_o;
        n_drop_o   = r_drop_o;
        w_cdiv_start = 1'b0;
        w_bdiv_start = 1'b0;

        case (r_state)
            S_CLR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(DEPTH - 1)) begin
                    n_clr_cnt = '0;
                    n_state   = S_IDLE;
                    if (r_clr_emit) begin
                        n_done   = 1'b1;
                        n_cnt_o  = '0;
                        n_vz_o   = '0;
                        n_sq_o   = '0;
                        n_drop_o = 1'b0;
                    end
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt_o  = '0;
                    n_vz_o   = '0;
                    n_sq_o   = '0;
                    n_drop_o = 1'b0;
                    n_drop   = 1'b0;
                    case (t_op'(i_opcode))
                        OP_ATOM: begin
                            if (r_tally == '0) begin
                                n_type = i_mol_type;
                            end
                            if (32'(r_tally) < MAX_ATOMS_PER_MOL) begin
                                n_z_acc  = r_z_acc  + ACC_W'(i_pos_z);
                                n_vx_acc = r_vx_acc + ACC_W'(i_vel_x);
                                n_vy_acc = r_vy_acc + ACC_W'(i_vel_y);
                                n_vz_acc = r_vz_acc + ACC_W'(i_vel_z);
                                n_tally  = r_tally + 1'b1;
                            end
                            if (i_end_of_molecule) begin
                                n_eof   = 1'b0;
                                n_state = S_FIN;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (w_rd_ok) begin
                                n_addr = AW'((32'(i_resolution_select) * NUM_TYPES
                                              + 32'(i_mol_type)) * MAX_BINS
                                             + 32'(i_bin_index));
                                n_state = S_RD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_z_acc    = '0;
                            n_vx_acc   = '0;
                            n_vy_acc   = '0;
                            n_vz_acc   = '0;
                            n_tally    = '0;
                            n_frames   = '0;
                            n_clr_cnt  = '0;
                            n_clr_emit = 1'b1;
                            n_state    = S_CLR;
                        end
                        default: begin
                            n_eof   = 1'b1;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (r_tally == '0) begin
                    n_state = S_BIN;
                    n_res   = 3'(NR_ACT);
                end else begin
                    w_cdiv_start = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (w_cdiv_done) begin
                    n_cz  = r_z_acc[ACC_W-1]  ? -CEN_W'(w_quo[0]) : CEN_W'(w_quo[0]);
                    n_cvx = r_vx_acc[ACC_W-1] ? -CEN_W'(w_quo[1]) : CEN_W'(w_quo[1]);
                    n_cvy = r_vy_acc[ACC_W-1] ? -CEN_W'(w_quo[2]) : CEN_W'(w_quo[2]);
                    n_cvz = r_vz_acc[ACC_W-1] ? -CEN_W'(w_quo[3]) : CEN_W'(w_quo[3]);
                    n_k   = '0;
                    n_sq  = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                // one square per cycle, registered in r_prod and then accumulated
                n_prod = (2*CEN_W)'(w_sq_sel * w_sq_sel);
                n_k    = r_k + 1'b1;
                if (r_k != 2'd0) begin
                    n_sq = r_sq + 64'(r_prod);
                end
                if (r_k == 2'd3) begin
                    n_res   = '0;
                    n_state = S_BIN;
                end
            end
            S_BIN: begin
                if (r_res == 3'(NR_ACT)) begin
                    if (r_eof && (r_frames != 32'hFFFF_FFFF)) begin
                        n_frames = r_frames + 32'd1;
                    end
                    n_z_acc  = '0;
                    n_vx_acc = '0;
                    n_vy_acc = '0;
                    n_vz_acc = '0;
                    n_tally  = '0;
                    n_done   = 1'b1;
                    n_drop_o = r_drop;
                    n_state  = S_IDLE;
                end else if ((32'(r_type) >= NUM_TYPES) || r_cz[CEN_W-1] || (r_box == '0)) begin
                    n_drop = 1'b1;
                    n_res  = r_res + 1'b1;
                end else begin
                    w_bdiv_start = 1'b1;
                    n_state      = S_BWAIT;
                end
            end
            S_BWAIT: begin
                if (w_bdiv_done) begin
                    if ((w_bquo >= PROD_W'(w_bins_cur)) || (w_bquo >= PROD_W'(MAX_BINS))) begin
                        n_drop  = 1'b1;
                        n_res   = r_res + 1'b1;
                        n_state = S_BIN;
                    end else begin
                        n_addr = AW'((32'(r_res) * NUM_TYPES + 32'(r_type)) * MAX_BINS
                                     + 32'(w_bquo[BINS_W-1:0]));
                        n_state = S_RMW_RD;
                    end
                end
            end
            S_RMW_RD: begin
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                n_res   = r_res + 1'b1;
                n_state = S_BIN;
            end
            S_RD: begin
                n_state = S_RRET;
            end
            S_RRET: begin
                n_done  = 1'b1;
                n_cnt_o = w_old.cnt;
                n_vz_o  = w_old.vz;
                n_sq_o  = w_old.sq;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_z_acc    <= '0;
            r_vx_acc   <= '0;
            r_vy_acc   <= '0;
            r_vz_acc   <= '0;
            r_tally    <= '0;
            r_type     <= '0;
            r_eof      <= 1'b0;
            r_drop     <= 1'b0;
            r_k        <= '0;
            r_res      <= '0;
            r_clr_cnt  <= '0;
            r_clr_emit <= 1'b0;
            r_frames   <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_z_acc    <= n_z_acc;
            r_vx_acc   <= n_vx_acc;
            r_vy_acc   <= n_vy_acc;
            r_vz_acc   <= n_vz_acc;
            r_tally    <= n_tally;
            r_type     <= n_type;
            r_eof      <= n_eof;
            r_drop     <= n_drop;
            r_k        <= n_k;
            r_res      <= n_res;
            r_clr_cnt  <= n_clr_cnt;
            r_clr_emit <= n_clr_emit;
            r_frames   <= n_frames;
            r_done     <= n_done;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_cz     <= n_cz;
        r_cvx    <= n_cvx;
        r_cvy    <= n_cvy;
        r_cvz    <= n_cvz;
        r_prod   <= n_prod;
        r_sq     <= n_sq;
        r_addr   <= n_addr;
        r_cnt_o  <= n_cnt_o;
        r_vz_o   <= n_vz_o;
        r_sq_o   <= n_sq_o;
        r_drop_o <= n_drop_o;
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= BOX_Z_RST;
            for (int i = 0; i < NUM_REG; i++) begin
                r_bins[i] <= BINS_RST[i];
            end
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_BOX_Z: r_box     <= i_cfg_data[BOX_W-1:0];
                REG_BINS0: r_bins[0] <= i_cfg_data[BINS_W-1:0];
                REG_BINS1: r_bins[1] <= i_cfg_data[BINS_W-1:0];
                REG_BINS2: r_bins[2] <= i_cfg_data[BINS_W-1:0];
                REG_BINS3: r_bins[3] <= i_cfg_data[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_entry_count  = r_cnt_o;
    assign o_vz_sum       = r_vz_o;
    assign o_speed_sq_sum = r_sq_o;
    assign o_frames_seen  = r_frames;
    assign o_dropped      = r_drop_o;
endmodule
`default_nettype wire

@@ rtl/msph_chk.sv @@
`default_nettype none
module msph_chk
    import msph_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [1:0]         i_opcode,
    input wire logic               i_end_of_molecule,
    input wire logic               o_done,
    input wire logic               o_dropped,
    input wire logic [31:0]        o_entry_count,
    input wire logic signed [63:0] o_vz_sum,
    input wire logic [63:0]        o_speed_sq_sum
);
    logic w_acc;
    assign w_acc = start && !busy;

    // no result strobe straight out of reset
    a_no_done_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

    // a clear beat starts the sweep
    a_clear_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_opcode == OP_CLEAR)) |=> busy)
        else $error("clear did not start sweep");

    // an atom that does not end its molecule answers next cycle
    a_atom_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_opcode == OP_ATOM) && !i_end_of_molecule) |=> (o_done && !busy))
        else $error("plain atom result late");

    // a dropped flag only comes with empty read fields
    a_drop_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dropped) |->
            ((o_entry_count == 32'd0) && (o_vz_sum == 64'sd0) && (o_speed_sq_sum == 64'd0)))
        else $error("drop with read data");
endmodule

bind molecule_slab_profile_histogram msph_chk u_msph_chk (.*);
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
module testbench;
    import msph_pkg::*;

    // DUT ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_opcode = OP_ATOM;
    logic [2:0]         i_mol_type = '0;
    logic               i_end_of_molecule = 1'b0;
    logic signed [24:0] i_pos_z = '0;
    logic signed [24:0] i_vel_x = '0;
    logic signed [24:0] i_vel_y = '0;
    logic signed [24:0] i_vel_z = '0;
    logic [1:0]         i_resolution_select = '0;
    logic [8:0]         i_bin_index = '0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = REG_BOX_Z;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               o_done;
    logic [31:0]        o_entry_count;
    logic signed [63:0] o_vz_sum;
    logic [63:0]        o_speed_sq_sum;
    logic [31:0]        o_frames_seen;
    logic               o_dropped;

    molecule_slab_profile_histogram u_top (.*);

    always #5 i_clk = ~i_clk;

    // one expected result beat
    typedef struct {
        logic [31:0]        cnt;
        logic signed [63:0] vz;
        logic [63:0]        sq;
        logic [31:0]        frames;
        logic               drop;
    } t_slab_result;

    t_slab_result slab_results_due[$];

    // shadow of the block: config, per-molecule sums and the sparse tables
    longint unsigned  box_cfg;
    longint unsigned  bins_cfg [4];
    longint           z_sum, vx_sum, vy_sum, vz_sum;
    int unsigned      atoms_in_mol;
    logic [2:0]       mol_type_q;
    int unsigned      bin_count_tab [int];
    longint           bin_vz_tab [int];
    longint unsigned  bin_sq_tab [int];
    logic [31:0]      frame_tally;

    // last finished molecule, used to aim reads at live bins
    longint           last_cz;
    logic [2:0]       last_type;

    int               mismatches = 0;
    int               beats_sent = 0;
    int               gap_pct = 0;

    function automatic longint trunc_div(longint s, int unsigned n);
        longint unsigned mag;
        longint q;
        mag = (s < 0) ? longint'(-s) : longint'(s);
        q = longint'(mag / n);
        return (s < 0) ? -q : q;
    endfunction

    function automatic void drop_pending();
        z_sum = 0; vx_sum = 0; vy_sum = 0; vz_sum = 0;
        atoms_in_mol = 0;
    endfunction

    // centroid, squared speed and the four slab updates; returns the drop flag
    function automatic logic close_molecule();
        logic drop;
        longint cz, cvx, cvy, cvz;
        longint unsigned sq, q;
        int idx;
        drop = 1'b0;
        if (atoms_in_mol == 0) return 1'b0;
        cz  = trunc_div(z_sum, atoms_in_mol);
        cvx = trunc_div(vx_sum, atoms_in_mol);
        cvy = trunc_div(vy_sum, atoms_in_mol);
        cvz = trunc_div(vz_sum, atoms_in_mol);
        sq  = longint'(cvx * cvx) + longint'(cvy * cvy) + longint'(cvz * cvz);
        last_cz = cz;
        last_type = mol_type_q;
        for (int r = 0; r < 4; r++) begin
            if (cz < 0 || box_cfg == 0) begin
                drop = 1'b1;
                continue;
            end
            q = (longint'(cz) * bins_cfg[r]) / box_cfg;
            if (q >= bins_cfg[r] || q >= 512) begin
                drop = 1'b1;
                continue;
            end
            idx = (r * 8 + int'(mol_type_q)) * 512 + int'(q);
            if (!bin_count_tab.exists(idx)) begin
                bin_count_tab[idx] = 0;
                bin_vz_tab[idx] = 0;
                bin_sq_tab[idx] = 0;
            end
            if (bin_count_tab[idx] != 32'hFFFF_FFFF) bin_count_tab[idx]++;
            if (cvz > 0 && bin_vz_tab[idx] > 64'sh7FFF_FFFF_FFFF_FFFF - cvz)
                bin_vz_tab[idx] = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (cvz < 0 && bin_vz_tab[idx] < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - cvz)
                bin_vz_tab[idx] = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
            else
                bin_vz_tab[idx] += cvz;
            if (bin_sq_tab[idx] > 64'hFFFF_FFFF_FFFF_FFFF - sq)
                bin_sq_tab[idx] = 64'hFFFF_FFFF_FFFF_FFFF;
            else
                bin_sq_tab[idx] += sq;
        end
        drop_pending();
        return drop;
    endfunction

    function automatic t_slab_result predict_beat(t_op op, logic [2:0] typ, logic eom,
            logic signed [24:0] pz, vx, vy, vz, logic [1:0] res, logic [8:0] bin);
        t_slab_result e;
        int idx;
        e = '{cnt: 0, vz: 0, sq: 0, frames: 0, drop: 1'b0};
        case (op)
            OP_ATOM: begin
                if (atoms_in_mol == 0) mol_type_q = typ;
                if (atoms_in_mol < 64) begin
                    z_sum += pz; vx_sum += vx; vy_sum += vy; vz_sum += vz;
                    atoms_in_mol++;
                end
                if (eom) e.drop = close_molecule();
            end
            OP_READ: begin
                idx = (int'(res) * 8 + int'(typ)) * 512 + int'(bin);
                if (bin_count_tab.exists(idx)) begin
                    e.cnt = bin_count_tab[idx];
                    e.vz  = bin_vz_tab[idx];
                    e.sq  = bin_sq_tab[idx];
                end
            end
            OP_CLEAR: begin
                bin_count_tab.delete();
                bin_vz_tab.delete();
                bin_sq_tab.delete();
                frame_tally = 0;
                drop_pending();
            end
            default: begin
                // end of frame flushes a molecule left open
                e.drop = close_molecule();
                if (frame_tally != 32'hFFFF_FFFF) frame_tally++;
            end
        endcase
        e.frames = frame_tally;
        return e;
    endfunction

    // result checker: one beat per o_done, oldest expectation first
    always @(posedge i_clk) begin
        t_slab_result e;
        if (i_rst_n && o_done) begin
            if (slab_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
                e = slab_results_due.pop_front();
                if (o_entry_count !== e.cnt || o_vz_sum !== e.vz || o_speed_sq_sum !== e.sq
                        || o_frames_seen !== e.frames || o_dropped !== e.drop) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp cnt=%0d vz=%0d sq=%0d frm=%0d drop=%0d,",
                                 $realtime, e.cnt, e.vz, e.sq, e.frames, e.drop,
                                 " got cnt=%0d vz=%0d sq=%0d frm=%0d drop=%0d",
                                 o_entry_count, o_vz_sum, o_speed_sq_sum, o_frames_seen,
                                 o_dropped);
                end
            end
        end
    end

    // start stays high on return; the caller lowers it through idle_cycles
    task automatic send_beat(t_op op, logic [2:0] typ, logic eom,
            logic signed [24:0] pz, vx, vy, vz, logic [1:0] res, logic [8:0] bin);
        i_opcode <= op; i_mol_type <= typ; i_end_of_molecule <= eom;
        i_pos_z <= pz; i_vel_x <= vx; i_vel_y <= vy; i_vel_z <= vz;
        i_resolution_select <= res; i_bin_index <= bin;
        start <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        slab_results_due.push_back(predict_beat(op, typ, eom, pz, vx, vy, vz, res, bin));
        beats_sent++;
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(99) < gap_pct) idle_cycles($urandom_range(1, 6));
    endtask

    function automatic logic signed [24:0] rnd25();
        return 25'($urandom());
    endfunction

    task automatic send_atom(logic [2:0] typ, logic eom, logic signed [24:0] pz, vx, vy, vz);
        send_beat(OP_ATOM, typ, eom, pz, vx, vy, vz, $urandom(), $urandom());
    endtask

    task automatic send_read(logic [1:0] res, logic [2:0] typ, logic [8:0] bin);
        send_beat(OP_READ, typ, $urandom(), rnd25(), rnd25(), rnd25(), rnd25(), res, bin);
    endtask

    task automatic send_op(t_op op);
        send_beat(op, $urandom(), $urandom(), rnd25(), rnd25(), rnd25(), rnd25(),
                  $urandom(), $urandom());
    endtask

    // drain, then write while idle
    task automatic write_reg(t_reg_idx idx, int unsigned val);
        start <= 1'b0;
        while (slab_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_BOX_Z) box_cfg = val & 24'hFFFFFF;
        else bins_cfg[int'(idx) - 1] = val & 10'h3FF;
    endtask

    task automatic set_geometry(int unsigned box, int unsigned b0, b1, b2, b3);
        write_reg(REG_BOX_Z, box);
        write_reg(REG_BINS0, b0);
        write_reg(REG_BINS1, b1);
        write_reg(REG_BINS2, b2);
        write_reg(REG_BINS3, b3);
    endtask

    // read back every resolution at the bins of the last finished molecule
    task automatic read_last_molecule();
        longint unsigned q;
        for (int r = 0; r < 4; r++) begin
            q = (last_cz < 0 || box_cfg == 0) ? 0 :
                (longint'(last_cz) * bins_cfg[r]) / box_cfg;
            send_read(r, last_type, q[8:0]);
        end
    endtask

    task automatic test_directed();
        // full-scale coordinates and velocities, one-atom molecules
        send_atom(3'd0, 1'b1, 25'sd0, 25'sd16777215, -25'sd16777216, 25'sd16777215);
        send_atom(3'd7, 1'b1, 25'sd9999, -25'sd16777216, 25'sd16777215, -25'sd16777216);
        send_atom(3'd2, 1'b1, 25'sd16777215, 25'sd1, 25'sd1, 25'sd1);   // past box
        send_atom(3'd3, 1'b1, -25'sd16777216, 25'sd1, 25'sd1, 25'sd1);  // negative z
        // type latched from first atom; truncating division of odd sums
        send_atom(3'd5, 1'b0, 25'sd1000, -25'sd7, 25'sd3, -25'sd5);
        send_atom(3'd1, 1'b0, 25'sd1001, 25'sd0, 25'sd0, 25'sd0);
        send_atom(3'd6, 1'b1, 25'sd1001, 25'sd0, 25'sd0, 25'sd0);
        read_last_molecule();
        // too many atoms: beyond 64 not summed
        for (int i = 0; i < 70; i++)
            send_atom(3'd4, i == 69, (i < 64) ? 25'sd5000 : -25'sd16777216,
                      25'sd100, -25'sd100, 25'sd50);
        read_last_molecule();
        // end of frame flushes an open molecule, then one with nothing open
        send_atom(3'd1, 1'b0, 25'sd2500, 25'sd10, 25'sd20, 25'sd30);
        send_op(OP_EOF);
        read_last_molecule();
        send_op(OP_EOF);
        send_read(2'd3, 3'd7, 9'd511);
        send_read(2'd0, 3'd0, 9'd0);
        // clear drops tables, frame count and the open molecule
        send_atom(3'd2, 1'b0, 25'sd100, 25'sd1, 25'sd1, 25'sd1);
        send_op(OP_CLEAR);
        send_atom(3'd3, 1'b1, 25'sd200, 25'sd2, 25'sd2, 25'sd2);
        read_last_molecule();
        idle_cycles(1);
    endtask

    task automatic random_molecule();
        int n;
        logic [2:0] typ;
        longint zbase, z;
        logic open_end;
        n = ($urandom_range(99) < 4) ? $urandom_range(60, 70) : $urandom_range(1, 4);
        typ = $urandom();
        case ($urandom_range(9))
            0: zbase = -longint'($urandom_range(16777216));
            1: zbase = box_cfg + $urandom_range(1000);
            default: zbase = (box_cfg == 0) ? 0 : $urandom_range(box_cfg - 1);
        endcase
        open_end = ($urandom_range(99) < 10);
        for (int i = 0; i < n; i++) begin
            z = zbase + $signed($urandom_range(40)) - 20;
            if (z > 16777215) z = 16777215;
            if (z < -16777216) z = -16777216;
            maybe_gap();
            if ($urandom_range(3) == 0)
                send_atom(i == 0 ? typ : $urandom(), (i == n - 1) && !open_end, z,
                          rnd25(), rnd25(), rnd25());
            else
                send_atom(i == 0 ? typ : $urandom(), (i == n - 1) && !open_end, z,
                          $signed($urandom_range(4000)) - 2000,
                          $signed($urandom_range(4000)) - 2000,
                          $signed($urandom_range(4000)) - 2000);
        end
    endtask

    task automatic random_traffic(int beats, int pct);
        int stop_at, pick;
        gap_pct = pct;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(99);
            maybe_gap();
            if (pick < 55) random_molecule();
            else if (pick < 75) read_last_molecule();
            else if (pick < 87) send_read($urandom(), $urandom(), $urandom());
            else if (pick < 98) send_op(OP_EOF);
            else if (pick < 99) send_op(OP_CLEAR);
            else begin
                // noise atom with any bit pattern
                send_beat(OP_ATOM, $urandom(), $urandom(), rnd25(), rnd25(), rnd25(),
                          rnd25(), $urandom(), $urandom());
            end
            // stretches with no idling inside a phase
            if ($urandom_range(99) < 5) gap_pct = (gap_pct == 0) ? pct : 0;
        end
        idle_cycles(1);
    endtask

    task automatic test_default_geometry();
        random_traffic(330, 0);
    endtask

    task automatic test_fine_geometry();
        set_geometry(24'hFFFFFF, 10'd512, 10'd1, 10'd512, 10'd7);
        random_traffic(330, 50);
    endtask

    task automatic test_tiny_box();
        set_geometry(24'd1, 10'd1, 10'd512, 10'd3, 10'd255);
        random_traffic(120, 0);
    endtask

    task automatic test_random_geometry();
        set_geometry($urandom_range(100, 20000), $urandom_range(1, 512),
                     $urandom_range(1, 512), $urandom_range(1, 512), $urandom_range(1, 512));
        random_traffic(330, 32);
        set_geometry(24'd10000, 10'd50, 10'd100, 10'd200, 10'd300);
        random_traffic(200, 50);
    endtask

    initial begin
        box_cfg = 10000;
        bins_cfg = '{50, 100, 200, 300};
        drop_pending();
        mol_type_q = '0;
        frame_tally = '0;
        last_cz = 0;
        last_type = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_default_geometry();
        test_fine_geometry();
        test_tiny_box();
        test_random_geometry();
        start <= 1'b0;
        while (slab_results_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && slab_results_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog: far beyond the slowest legal run, clearing passes included
    initial begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
